>>> design/hswc_pkg.sv
package hswc_pkg;

  localparam int SEQ_BITS_DEF       = 16;
  localparam int CHALLENGE_BITS_DEF = 32;
  localparam int RES_Q_DEPTH        = 4;

  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;

  typedef enum logic [2:0] {
    KIND_OPEN,
    KIND_CLOSE,
    KIND_ACTION,
    KIND_RX,
    KIND_TICK
  } kind_t;

  typedef enum logic [1:0] {
    PKT_CONNECT,
    PKT_STATUS,
    PKT_ACTION,
    PKT_CLOSE
  } pkt_t;

  typedef enum logic [1:0] {
    LINK_DOWN,
    LINK_HANDSHAKE,
    LINK_UP
  } link_t;

  typedef enum logic [1:0] {
    OUTC_NONE,
    OUTC_ACKED,
    OUTC_FUTURE,
    OUTC_EXHAUSTED
  } outcome_t;

  typedef enum logic {
    CFG_RETRY_LIMIT,
    CFG_ACK_TIMEOUT
  } cfg_idx_t;

  // Fixed-width part of one result; seq and payload travel beside it.
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_dest;
    pkt_t       send_type;
    logic       send_syn;
    logic       send_ack;
    outcome_t   outcome;
    link_t      link_state;
    logic       last;
  } meta_t;

  typedef struct packed {
    logic en;
    logic two;
  } push_t;

  function automatic meta_t mk_meta(logic valid, logic [7:0] dest, pkt_t ptype, logic syn,
                                    logic ack, outcome_t outc);
    meta_t m;
    m            = '0;
    m.send_valid = valid;
    m.send_dest  = dest;
    m.send_type  = ptype;
    m.send_syn   = syn;
    m.send_ack   = ack;
    m.outcome    = outc;
    return m;
  endfunction

endpackage

>>> design/hswc_core.sv
module hswc_core #(
  parameter int SEQ_BITS       = hswc_pkg::SEQ_BITS_DEF,
  parameter int CHALLENGE_BITS = hswc_pkg::CHALLENGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      acc,
  input  logic [2:0]                kind,
  input  logic [7:0]                peer_id,
  input  logic [7:0]                action_code,
  input  logic [1:0]                rx_type,
  input  logic                      rx_syn,
  input  logic                      rx_ack,
  input  logic                      rx_nak,
  input  logic [SEQ_BITS-1:0]       rx_seq,
  input  logic [CHALLENGE_BITS-1:0] rx_challenge,
  output hswc_pkg::meta_t           res0_meta,
  output logic [SEQ_BITS-1:0]       res0_seq,
  output logic [CHALLENGE_BITS-1:0] res0_payload,
  output hswc_pkg::meta_t           res1_meta,
  output logic [SEQ_BITS-1:0]       res1_seq,
  output logic [CHALLENGE_BITS-1:0] res1_payload,
  output logic                      two_res
);

  logic [3:0]          retry_limit_r;
  logic [15:0]         ack_timeout_r;

  hswc_pkg::link_t     link_mode_r, link_mode_nxt;
  logic [7:0]          peer_addr_r, peer_addr_nxt;
  logic [SEQ_BITS-1:0] next_seq_r, next_seq_nxt;
  logic                awaiting_r, awaiting_nxt;
  logic [3:0]          attempts_r, attempts_nxt;
  logic [15:0]         timer_r, timer_nxt;
  logic                ack_seen_r, ack_seen_nxt;
  logic [SEQ_BITS-1:0] ack_max_r, ack_max_nxt;
  logic [7:0]          pending_r, pending_nxt;

  logic                dec_en;
  logic [SEQ_BITS-1:0] dec_v;
  logic [SEQ_BITS-1:0] folded_max;
  logic [15:0]         timer_inc;
  logic [3:0]          att_inc;
  hswc_pkg::meta_t     m0, m1;

  always_comb begin
    link_mode_nxt = link_mode_r;
    peer_addr_nxt = peer_addr_r;
    next_seq_nxt  = next_seq_r;
    awaiting_nxt  = awaiting_r;
    attempts_nxt  = attempts_r;
    timer_nxt     = timer_r;
    ack_seen_nxt  = ack_seen_r;
    ack_max_nxt   = ack_max_r;
    pending_nxt   = pending_r;
    m0            = '0;
    m1            = '0;
    res0_seq      = '0;
    res0_payload  = '0;
    res1_seq      = '0;
    res1_payload  = '0;
    two_res       = 1'b0;
    dec_en        = 1'b0;
    dec_v         = '0;
    folded_max    = (!ack_seen_r || rx_seq > ack_max_r) ? rx_seq : ack_max_r;
    timer_inc     = (timer_r != 16'hFFFF) ? timer_r + 16'd1 : timer_r;
    att_inc       = (attempts_r != 4'hF) ? attempts_r + 4'd1 : attempts_r;

    case (hswc_pkg::kind_t'(kind))
      hswc_pkg::KIND_OPEN: begin
        if (link_mode_r == hswc_pkg::LINK_DOWN) begin
          peer_addr_nxt = peer_id;
          link_mode_nxt = hswc_pkg::LINK_HANDSHAKE;
          next_seq_nxt  = SEQ_BITS'(1);
          m0 = hswc_pkg::mk_meta(1'b1, peer_id, hswc_pkg::PKT_CONNECT, 1'b1, 1'b0,
                                 hswc_pkg::OUTC_NONE);
        end
      end
      hswc_pkg::KIND_CLOSE: begin
        if (link_mode_r != hswc_pkg::LINK_DOWN) begin
          m0 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_CLOSE, 1'b0, 1'b0,
                                 hswc_pkg::OUTC_NONE);
          res0_seq      = next_seq_r;
          link_mode_nxt = hswc_pkg::LINK_DOWN;
          next_seq_nxt  = '0;
          peer_addr_nxt = '0;
          awaiting_nxt  = 1'b0;
          attempts_nxt  = '0;
          timer_nxt     = '0;
        end
      end
      hswc_pkg::KIND_ACTION: begin
        if (!awaiting_r) begin
          pending_nxt  = action_code;
          awaiting_nxt = 1'b1;
          attempts_nxt = '0;
          timer_nxt    = '0;
          m0 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_ACTION, 1'b0, 1'b0,
                                 hswc_pkg::OUTC_NONE);
          res0_seq     = next_seq_r;
          res0_payload = CHALLENGE_BITS'(action_code);
          // no retransmissions allowed: give up immediately
          if (retry_limit_r == 4'd0) begin
            two_res = 1'b1;
            if (link_mode_r != hswc_pkg::LINK_DOWN) begin
              m1 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_CLOSE, 1'b0, 1'b0,
                                     hswc_pkg::OUTC_EXHAUSTED);
              res1_seq = next_seq_r;
            end else begin
              m1 = hswc_pkg::mk_meta(1'b0, 8'd0, hswc_pkg::PKT_CONNECT, 1'b0, 1'b0,
                                     hswc_pkg::OUTC_EXHAUSTED);
            end
            link_mode_nxt = hswc_pkg::LINK_DOWN;
            next_seq_nxt  = '0;
            peer_addr_nxt = '0;
            awaiting_nxt  = 1'b0;
            attempts_nxt  = '0;
            timer_nxt     = '0;
          end
        end
      end
      hswc_pkg::KIND_RX: begin
        case (hswc_pkg::pkt_t'(rx_type))
          hswc_pkg::PKT_CONNECT: begin
            if (link_mode_r == hswc_pkg::LINK_HANDSHAKE && rx_syn && rx_ack) begin
              m0 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_CONNECT, 1'b0, 1'b1,
                                     hswc_pkg::OUTC_NONE);
              res0_payload  = ~rx_challenge;
              link_mode_nxt = hswc_pkg::LINK_UP;
            end
          end
          hswc_pkg::PKT_STATUS: begin
            if (!rx_nak) begin
              ack_max_nxt  = folded_max;
              ack_seen_nxt = 1'b1;
              dec_en       = awaiting_r;
              dec_v        = folded_max;
            end
          end
          hswc_pkg::PKT_CLOSE: begin
            link_mode_nxt = hswc_pkg::LINK_DOWN;
            next_seq_nxt  = '0;
            peer_addr_nxt = '0;
            awaiting_nxt  = 1'b0;
            attempts_nxt  = '0;
            timer_nxt     = '0;
          end
          default: begin
          end
        endcase
      end
      hswc_pkg::KIND_TICK: begin
        if (awaiting_r) begin
          if (ack_seen_r) begin
            dec_en = 1'b1;
            dec_v  = ack_max_r;
          end else begin
            timer_nxt = timer_inc;
            // timeout counts as an ack of zero
            if (timer_inc >= ack_timeout_r) begin
              dec_en = 1'b1;
              dec_v  = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (dec_en) begin
      ack_seen_nxt = 1'b0;
      ack_max_nxt  = '0;
      if (dec_v > next_seq_r) begin
        m0 = hswc_pkg::mk_meta(link_mode_r != hswc_pkg::LINK_DOWN, peer_addr_r,
                               (link_mode_r != hswc_pkg::LINK_DOWN) ? hswc_pkg::PKT_CLOSE
                                                                    : hswc_pkg::PKT_CONNECT,
                               1'b0, 1'b0, hswc_pkg::OUTC_FUTURE);
        if (link_mode_r == hswc_pkg::LINK_DOWN) m0.send_dest = '0;
        res0_seq      = (link_mode_r != hswc_pkg::LINK_DOWN) ? next_seq_r : '0;
        link_mode_nxt = hswc_pkg::LINK_DOWN;
        next_seq_nxt  = '0;
        peer_addr_nxt = '0;
        awaiting_nxt  = 1'b0;
        attempts_nxt  = '0;
        timer_nxt     = '0;
      end else if (dec_v == next_seq_r) begin
        next_seq_nxt = next_seq_r + SEQ_BITS'(1);
        awaiting_nxt = 1'b0;
        attempts_nxt = '0;
        timer_nxt    = '0;
        m0 = hswc_pkg::mk_meta(1'b0, 8'd0, hswc_pkg::PKT_CONNECT, 1'b0, 1'b0,
                               hswc_pkg::OUTC_ACKED);
      end else begin
        // retransmit
        m0 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_ACTION, 1'b0, 1'b0,
                               hswc_pkg::OUTC_NONE);
        res0_seq     = next_seq_r;
        res0_payload = CHALLENGE_BITS'(pending_r);
        attempts_nxt = att_inc;
        timer_nxt    = '0;
        if (att_inc >= retry_limit_r) begin
          two_res = 1'b1;
          if (link_mode_r != hswc_pkg::LINK_DOWN) begin
            m1 = hswc_pkg::mk_meta(1'b1, peer_addr_r, hswc_pkg::PKT_CLOSE, 1'b0, 1'b0,
                                   hswc_pkg::OUTC_EXHAUSTED);
            res1_seq = next_seq_r;
          end else begin
            m1 = hswc_pkg::mk_meta(1'b0, 8'd0, hswc_pkg::PKT_CONNECT, 1'b0, 1'b0,
                                   hswc_pkg::OUTC_EXHAUSTED);
          end
          link_mode_nxt = hswc_pkg::LINK_DOWN;
          next_seq_nxt  = '0;
          peer_addr_nxt = '0;
          awaiting_nxt  = 1'b0;
          attempts_nxt  = '0;
          timer_nxt     = '0;
        end
      end
    end

    m0.link_state = link_mode_nxt;
    m1.link_state = link_mode_nxt;
    m0.last       = !two_res;
    m1.last       = 1'b1;
    res0_meta     = m0;
    res1_meta     = m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= hswc_pkg::RETRY_LIMIT_RST;
      ack_timeout_r <= hswc_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (hswc_pkg::cfg_idx_t'(cfg_index))
        hswc_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[3:0];
        hswc_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_mode_r <= hswc_pkg::LINK_DOWN;
      peer_addr_r <= '0;
      next_seq_r  <= '0;
      awaiting_r  <= 1'b0;
      attempts_r  <= '0;
      timer_r     <= '0;
      ack_seen_r  <= 1'b0;
      ack_max_r   <= '0;
      pending_r   <= '0;
    end else if (acc) begin
      link_mode_r <= link_mode_nxt;
      peer_addr_r <= peer_addr_nxt;
      next_seq_r  <= next_seq_nxt;
      awaiting_r  <= awaiting_nxt;
      attempts_r  <= attempts_nxt;
      timer_r     <= timer_nxt;
      ack_seen_r  <= ack_seen_nxt;
      ack_max_r   <= ack_max_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

>>> design/hswc_resq.sv
module hswc_resq #(
  parameter int DW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hswc_pkg::push_t push,
  input  logic [DW-1:0]  wr0,
  input  logic [DW-1:0]  wr1,
  input  logic           pop,
  output logic           full2,
  output logic           rd_valid,
  output logic [DW-1:0]  rd_data
);

  localparam int DEPTH = hswc_pkg::RES_Q_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_push;
  logic          do_pop;

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  // room for a two-result item is required before taking any item
  assign full2    = (cnt_r > CW'(DEPTH - 2));
  assign do_pop   = pop && rd_valid;

  always_comb begin
    n_push  = push.en ? (push.two ? CW'(2) : CW'(1)) : '0;
    wp_nxt  = wp_r + PW'(n_push);
    rp_nxt  = do_pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + n_push - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      mem_r[wp_r] <= wr0;
      if (push.two) mem_r[wp_r + PW'(1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> design/handshake_stop_and_wait_client.sv
// Results: an event's results enter the result queue when the event transfers; the second
//   result of a two-result event follows the first out of the queue.
// Throughput: one event per cycle, bounded by one result per cycle from the 4-entry queue
//   while out_stall is low; the input stalls while fewer than two queue slots are free.
// Reset: synchronous active-low rst_n clears link state, empties the queue and restores
//   retry_limit = 5 and ack_timeout_ticks = 5000.
module handshake_stop_and_wait_client #(
  parameter int SEQ_BITS       = hswc_pkg::SEQ_BITS_DEF,
  parameter int CHALLENGE_BITS = hswc_pkg::CHALLENGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_kind,
  input  logic [7:0]                in_peer_id,
  input  logic [7:0]                in_action_code,
  input  logic [1:0]                in_rx_type,
  input  logic                      in_rx_syn,
  input  logic                      in_rx_ack,
  input  logic                      in_rx_nak,
  input  logic [SEQ_BITS-1:0]       in_rx_seq,
  input  logic [CHALLENGE_BITS-1:0] in_rx_challenge,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_send_valid,
  output logic [7:0]                out_send_dest,
  output logic [1:0]                out_send_type,
  output logic                      out_send_syn,
  output logic                      out_send_ack,
  output logic [SEQ_BITS-1:0]       out_send_seq,
  output logic [CHALLENGE_BITS-1:0] out_send_payload,
  output logic [1:0]                out_outcome,
  output logic [1:0]                out_link_state,
  output logic                      out_last
);

  localparam int DW = $bits(hswc_pkg::meta_t) + SEQ_BITS + CHALLENGE_BITS;

  logic                      acc;
  hswc_pkg::meta_t           r0_meta, r1_meta, q_meta;
  logic [SEQ_BITS-1:0]       r0_seq, r1_seq;
  logic [CHALLENGE_BITS-1:0] r0_pay, r1_pay;
  logic                      two_res;
  hswc_pkg::push_t           push;
  logic [DW-1:0]             q_data;

  assign acc      = in_valid && !in_stall;
  assign push.en  = acc;
  assign push.two = two_res;

  hswc_core #(
    .SEQ_BITS       (SEQ_BITS),
    .CHALLENGE_BITS (CHALLENGE_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .acc          (acc),
    .kind         (in_kind),
    .peer_id      (in_peer_id),
    .action_code  (in_action_code),
    .rx_type      (in_rx_type),
    .rx_syn       (in_rx_syn),
    .rx_ack       (in_rx_ack),
    .rx_nak       (in_rx_nak),
    .rx_seq       (in_rx_seq),
    .rx_challenge (in_rx_challenge),
    .res0_meta    (r0_meta),
    .res0_seq     (r0_seq),
    .res0_payload (r0_pay),
    .res1_meta    (r1_meta),
    .res1_seq     (r1_seq),
    .res1_payload (r1_pay),
    .two_res      (two_res)
  );

  hswc_resq #(
    .DW (DW)
  ) u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr0      ({r0_meta, r0_seq, r0_pay}),
    .wr1      ({r1_meta, r1_seq, r1_pay}),
    .pop      (!out_stall),
    .full2    (in_stall),
    .rd_valid (out_valid),
    .rd_data  (q_data)
  );

  assign {q_meta, out_send_seq, out_send_payload} = q_data;

  assign out_send_valid = q_meta.send_valid;
  assign out_send_dest  = q_meta.send_dest;
  assign out_send_type  = q_meta.send_type;
  assign out_send_syn   = q_meta.send_syn;
  assign out_send_ack   = q_meta.send_ack;
  assign out_outcome    = q_meta.outcome;
  assign out_link_state = q_meta.link_state;
  assign out_last       = q_meta.last;

endmodule

>>> design/hswc_checker.sv
module hswc_checker #(
  parameter int SEQ_BITS       = hswc_pkg::SEQ_BITS_DEF,
  parameter int CHALLENGE_BITS = hswc_pkg::CHALLENGE_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_send_valid,
  input logic [SEQ_BITS-1:0]       out_send_seq,
  input logic [CHALLENGE_BITS-1:0] out_send_payload,
  input logic                      out_last
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // an empty queue always has room
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

  // second result of an event is queued together with the first
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid)
    else $error("second result missing after non-last transfer");

  a_nopkt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> out_send_seq == '0 && out_send_payload == '0)
    else $error("packet fields nonzero without a packet");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_send_seq) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind handshake_stop_and_wait_client hswc_checker #(
  .SEQ_BITS       (SEQ_BITS),
  .CHALLENGE_BITS (CHALLENGE_BITS)
) u_hswc_checker (.*);
